### hw/rtl/apw_pkg.sv
package apw_pkg;

    // Fixed field widths of the item and result ports.
    localparam int WEIGHT_IN_BITS = 32;
    localparam int FRAC_IN_BITS   = 16;
    localparam int INDEX_OUT_BITS = 8;
    localparam int STATUS_BITS    = 2;

    // Width of one partial product operand taken from the running total.
    localparam int MUL_CHUNK_BITS = 32;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_ENTRIES   = 256;
    localparam int DEF_WEIGHT_BITS   = 32;
    localparam int DEF_FRACTION_BITS = 16;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_PICK = 1'b1;

    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_PICK,
        S_MUL,
        S_MACC,
        S_SEL,
        S_SCAN,
        S_DONE
    } t_apw_state;

    typedef struct packed {
        logic load_in;
        logic add;
        logic set_empty;
        logic mul_start;
        logic mul_issue;
        logic mul_acc;
        logic rd_next;
        logic scan_step;
        logic set_hit;
        logic out_load;
    } t_apw_cmd;

    typedef struct packed {
        logic empty;
        logic mul_last;
        logic scan_hit;
        logic out_free;
    } t_apw_sts;

endpackage

### hw/rtl/apw_ram.sv
module apw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/apw_ctrl.sv
module apw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_opcode,
    output logic              o_in_ready,
    input  apw_pkg::t_apw_sts i_sts,
    output apw_pkg::t_apw_cmd o_cmd
);
    import apw_pkg::*;

    t_apw_state r_state;
    t_apw_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = (i_opcode == OP_PICK) ? S_PICK : S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state = S_DONE;
            end
            S_PICK: begin
                if (i_sts.empty) begin
                    o_cmd.set_empty = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_issue = 1'b1;
                n_state = S_MACC;
            end
            S_MACC: begin
                o_cmd.mul_acc = 1'b1;
                n_state = i_sts.mul_last ? S_SEL : S_MUL;
            end
            S_SEL: begin
                // Address of slot 0 goes to the memory in this cycle.
                o_cmd.rd_next = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.scan_hit) begin
                    o_cmd.set_hit = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_next   = 1'b1;
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

### hw/rtl/apw_dp.sv
module apw_dp #(
    parameter int MAX_ENTRIES   = apw_pkg::DEF_MAX_ENTRIES,
    parameter int WEIGHT_BITS   = apw_pkg::DEF_WEIGHT_BITS,
    parameter int FRACTION_BITS = apw_pkg::DEF_FRACTION_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  apw_pkg::t_apw_cmd                  i_cmd,
    output apw_pkg::t_apw_sts                  o_sts,
    input  logic [apw_pkg::WEIGHT_IN_BITS-1:0] i_entry_weight,
    input  logic [apw_pkg::FRAC_IN_BITS-1:0]   i_random_fraction,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [apw_pkg::INDEX_OUT_BITS-1:0] o_picked_index,
    output logic [apw_pkg::STATUS_BITS-1:0]    o_status
);
    import apw_pkg::*;

    localparam int ADDR_BITS  = $clog2(MAX_ENTRIES);
    localparam int CNT_BITS   = $clog2(MAX_ENTRIES + 1);
    localparam int TOTAL_BITS = WEIGHT_BITS + ADDR_BITS;
    localparam int NCHUNK     = (TOTAL_BITS + MUL_CHUNK_BITS - 1) / MUL_CHUNK_BITS;
    localparam int CIDX_BITS  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int PAD_BITS   = NCHUNK * MUL_CHUNK_BITS;
    localparam int PART_BITS  = MUL_CHUNK_BITS + FRACTION_BITS;
    localparam int PROD_BITS  = PAD_BITS + FRACTION_BITS;

    logic [WEIGHT_BITS-1:0]    r_weight;
    logic [FRACTION_BITS-1:0]  r_frac;
    logic [CNT_BITS-1:0]       r_count;
    logic [TOTAL_BITS-1:0]     r_total;
    logic [CIDX_BITS-1:0]      r_cidx;
    logic [PART_BITS-1:0]      r_part;
    logic [PROD_BITS-1:0]      r_acc;
    logic [ADDR_BITS-1:0]      r_next_addr;
    logic [ADDR_BITS-1:0]      r_data_idx;
    logic [TOTAL_BITS-1:0]     r_run_sum;
    logic [INDEX_OUT_BITS-1:0] r_res_index;
    logic [STATUS_BITS-1:0]    r_res_status;
    logic                      r_out_valid;
    logic [INDEX_OUT_BITS-1:0] r_out_index;
    logic [STATUS_BITS-1:0]    r_out_status;

    logic                      full;
    logic                      ram_we;
    logic [WEIGHT_BITS-1:0]    ram_rdata;
    logic [PAD_BITS-1:0]       total_pad;
    logic [MUL_CHUNK_BITS-1:0] chunk;
    logic [PART_BITS-1:0]      n_part;
    logic [PROD_BITS-1:0]      n_acc;
    logic [TOTAL_BITS-1:0]     selector;
    logic [TOTAL_BITS-1:0]     n_run_sum;
    logic                      scan_last;

    assign full   = (r_count == CNT_BITS'(MAX_ENTRIES));
    assign ram_we = i_cmd.add && !full;

    apw_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[ADDR_BITS-1:0]),
        .i_wdata (r_weight),
        .i_raddr (r_next_addr),
        .o_rdata (ram_rdata)
    );

    // The total is multiplied one 32-bit slice at a time, top slice first,
    // so each accumulate step is a fixed shift and one add.
    assign total_pad = PAD_BITS'(r_total);
    assign chunk     = total_pad[r_cidx * MUL_CHUNK_BITS +: MUL_CHUNK_BITS];
    assign n_part    = PART_BITS'(chunk) * PART_BITS'(r_frac);
    assign n_acc     = (r_acc << MUL_CHUNK_BITS) + PROD_BITS'(r_part);
    assign selector  = r_acc[FRACTION_BITS +: TOTAL_BITS];

    // The read data belongs to slot r_data_idx. The last slot is taken
    // whether or not its running sum reaches the selector.
    assign n_run_sum = r_run_sum + TOTAL_BITS'(ram_rdata);
    assign scan_last = (CNT_BITS'(r_data_idx) == r_count - CNT_BITS'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (ram_we) begin
                r_count <= r_count + CNT_BITS'(1);
                r_total <= r_total + TOTAL_BITS'(r_weight);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_weight <= WEIGHT_BITS'(i_entry_weight);
            r_frac   <= FRACTION_BITS'(i_random_fraction);
        end
        if (i_cmd.mul_start) begin
            r_cidx      <= CIDX_BITS'(NCHUNK - 1);
            r_acc       <= '0;
            r_next_addr <= '0;
            r_data_idx  <= '0;
            r_run_sum   <= '0;
        end
        if (i_cmd.mul_issue) begin
            r_part <= n_part;
        end
        if (i_cmd.mul_acc) begin
            r_acc  <= n_acc;
            r_cidx <= r_cidx - CIDX_BITS'(1);
        end
        if (i_cmd.rd_next) begin
            r_next_addr <= r_next_addr + ADDR_BITS'(1);
        end
        if (i_cmd.scan_step) begin
            r_run_sum  <= n_run_sum;
            r_data_idx <= r_data_idx + ADDR_BITS'(1);
        end
        if (i_cmd.add) begin
            if (full) begin
                r_res_index  <= '0;
                r_res_status <= ST_FULL;
            end else begin
                r_res_index  <= INDEX_OUT_BITS'(r_count);
                r_res_status <= ST_OK;
            end
        end
        if (i_cmd.set_empty) begin
            r_res_index  <= '0;
            r_res_status <= ST_EMPTY;
        end
        if (i_cmd.set_hit) begin
            r_res_index  <= INDEX_OUT_BITS'(r_data_idx);
            r_res_status <= ST_OK;
        end
        if (i_cmd.out_load) begin
            r_out_index  <= r_res_index;
            r_out_status <= r_res_status;
        end
    end

    assign o_sts.empty    = (r_count == '0);
    assign o_sts.mul_last = (r_cidx == '0);
    assign o_sts.scan_hit = (selector <= n_run_sum) || scan_last;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_picked_index = r_out_index;
    assign o_status       = r_out_status;

`ifndef SYNTHESIS
    a_add_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> r_count == $past(r_count) + CNT_BITS'(1))
        else $error("entry count did not advance after a stored add");

    a_empty_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == '0 |-> r_total == '0)
        else $error("nonzero total with an empty table");

    a_hit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.set_hit |-> CNT_BITS'(r_data_idx) < r_count)
        else $error("picked slot beyond the stored entries");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !r_out_valid || i_out_ready)
        else $error("result register overwritten before it was taken");
`endif

endmodule

### hw/rtl/area_weighted_entry_picker.sv
// Add: the item passes through S_ADD and S_DONE; the next item is taken only after its result
// is loaded. Pick: C = ceil((WEIGHT_BITS + log2(MAX_ENTRIES)) / 32) multiply slices (2 by
// default) and k scanned slots (1 to MAX_ENTRIES), one memory read per slot; the next item is
// taken only after the result is loaded into the output register, which waits for it to be free.
// Pick on an empty table skips the multiply and scan and gives status EMPTY. Reset (synchronous,
// active low) empties the table and clears the total; the weight memory is not cleared.
module area_weighted_entry_picker #(
    parameter int MAX_ENTRIES   = apw_pkg::DEF_MAX_ENTRIES,
    parameter int WEIGHT_BITS   = apw_pkg::DEF_WEIGHT_BITS,
    parameter int FRACTION_BITS = apw_pkg::DEF_FRACTION_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_opcode,
    input  logic [apw_pkg::WEIGHT_IN_BITS-1:0] i_entry_weight,
    input  logic [apw_pkg::FRAC_IN_BITS-1:0]   i_random_fraction,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [apw_pkg::INDEX_OUT_BITS-1:0] o_picked_index,
    output logic [apw_pkg::STATUS_BITS-1:0]    o_status
);
    import apw_pkg::*;

    t_apw_cmd cmd;
    t_apw_sts sts;

    apw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    apw_dp #(
        .MAX_ENTRIES   (MAX_ENTRIES),
        .WEIGHT_BITS   (WEIGHT_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_entry_weight    (i_entry_weight),
        .i_random_fraction (i_random_fraction),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_picked_index    (o_picked_index),
        .o_status          (o_status)
    );

endmodule

### test/picker_result_checker.sv
`timescale 1ns / 100ps

module picker_result_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic                               i_opcode,
    input  logic [apw_pkg::WEIGHT_IN_BITS-1:0] i_entry_weight,
    input  logic [apw_pkg::FRAC_IN_BITS-1:0]   i_random_fraction,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic [apw_pkg::INDEX_OUT_BITS-1:0] i_picked_index,
    input  logic [apw_pkg::STATUS_BITS-1:0]    i_status,
    output int unsigned                        o_fail_count,
    output int unsigned                        o_pending
);
    import apw_pkg::*;

    localparam int MAX_ENTRIES   = DEF_MAX_ENTRIES;
    localparam int WEIGHT_BITS   = DEF_WEIGHT_BITS;
    localparam int FRACTION_BITS = DEF_FRACTION_BITS;
    localparam int ADDR_BITS     = $clog2(MAX_ENTRIES);
    localparam int REPORT_LIMIT  = 10;
    localparam int FIFO_DEPTH    = 8;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [INDEX_OUT_BITS-1:0] index;
        logic [STATUS_BITS-1:0]    status;
    } t_picker_result;

    logic [WEIGHT_BITS-1:0]   weight_table [MAX_ENTRIES];
    logic [8:0]               entry_count_q = '0;
    logic [63:0]              weight_sum_q  = '0;
    t_picker_result           expected_fifo [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr        = '0;
    logic [FIFO_PTR_BITS-1:0] rd_ptr        = '0;
    int unsigned              fifo_level    = 0;
    int unsigned              fail_total    = 0;

    // Applies one item to the local copy of the table and returns the result it should give.
    function automatic t_picker_result apply_item(input logic op,
                                                  input logic [WEIGHT_IN_BITS-1:0] weight,
                                                  input logic [FRAC_IN_BITS-1:0] fraction);
        t_picker_result res;
        logic [63:0]    selector;
        logic [63:0]    running;
        logic           found;
        int             slot;
        res.index  = '0;
        res.status = ST_OK;
        if (op == OP_ADD) begin
            if (entry_count_q >= MAX_ENTRIES) begin
                res.status = ST_FULL;
            end else begin
                res.index = entry_count_q[INDEX_OUT_BITS-1:0];
                weight_table[entry_count_q[ADDR_BITS-1:0]] = weight[WEIGHT_BITS-1:0];
                entry_count_q = entry_count_q + 1'b1;
                weight_sum_q  = weight_sum_q + 64'(weight[WEIGHT_BITS-1:0]);
            end
        end else if (entry_count_q == 0) begin
            res.status = ST_EMPTY;
        end else if (entry_count_q > 1) begin
            selector = (weight_sum_q * 64'(fraction[FRACTION_BITS-1:0])) >> FRACTION_BITS;
            running  = '0;
            found    = 1'b0;
            slot     = int'(entry_count_q) - 1;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (!found && i < int'(entry_count_q)) begin
                    running = running + 64'(weight_table[i]);
                    if (selector <= running) begin
                        found = 1'b1;
                        slot  = i;
                    end
                end
            end
            res.index = slot[INDEX_OUT_BITS-1:0];
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_picker_result want;
        if (!i_rst_n) begin
            entry_count_q = '0;
            weight_sum_q  = '0;
            wr_ptr        = '0;
            rd_ptr        = '0;
            fifo_level    = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                if (fifo_level == FIFO_DEPTH) begin
                    fail_total++;
                    if (fail_total <= REPORT_LIMIT) begin
                        $display("%0t: too many items accepted without a result", $realtime);
                    end
                end else begin
                    expected_fifo[wr_ptr] = apply_item(i_opcode, i_entry_weight,
                                                       i_random_fraction);
                    wr_ptr     = wr_ptr + 1'b1;
                    fifo_level = fifo_level + 1;
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (fifo_level == 0) begin
                    fail_total++;
                    if (fail_total <= REPORT_LIMIT) begin
                        $display("%0t: unexpected result index %0d status %0d", $realtime,
                                 i_picked_index, i_status);
                    end
                end else begin
                    want       = expected_fifo[rd_ptr];
                    rd_ptr     = rd_ptr + 1'b1;
                    fifo_level = fifo_level - 1;
                    if (want.index !== i_picked_index || want.status !== i_status) begin
                        fail_total++;
                        if (fail_total <= REPORT_LIMIT) begin
                            $display("%0t: expected index %0d status %0d, got %0d status %0d",
                                     $realtime, want.index, want.status, i_picked_index,
                                     i_status);
                        end
                    end
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= fifo_level;
    end

endmodule

### test/tb_area_weighted_entry_picker.sv
`timescale 1ns / 100ps

module tb_area_weighted_entry_picker;
    import apw_pkg::*;

    localparam int          CLK_PERIOD   = 10;
    localparam int          RESET_CYCLES = 10;
    localparam int          RANDOM_ITEMS = 1230;
    localparam int          QUIET_ITEMS  = 150;
    localparam int          HOLD_START   = 3000;
    localparam int          HOLD_CYCLES  = 600;
    localparam int          DRAIN_CYCLES = 300;
    localparam int unsigned CYCLE_LIMIT  = 1500000;

    logic                      clk             = 1'b0;
    logic                      rst_n           = 1'b0;
    logic                      in_valid        = 1'b0;
    logic                      in_ready;
    logic                      opcode          = OP_ADD;
    logic [WEIGHT_IN_BITS-1:0] entry_weight    = '0;
    logic [FRAC_IN_BITS-1:0]   random_fraction = '0;
    logic                      out_valid;
    logic                      out_ready       = 1'b0;
    logic [INDEX_OUT_BITS-1:0] picked_index;
    logic [STATUS_BITS-1:0]    status;
    logic                      quiet           = 1'b0;
    int unsigned               fail_count;
    int unsigned               pending;

    int unsigned rx_cycles      = 0;
    int unsigned stall_left     = 0;
    logic        long_hold_done = 1'b0;
    int unsigned cycle_count    = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    area_weighted_entry_picker dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_opcode          (opcode),
        .i_entry_weight    (entry_weight),
        .i_random_fraction (random_fraction),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_picked_index    (picked_index),
        .o_status          (status)
    );

    picker_result_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_opcode          (opcode),
        .i_entry_weight    (entry_weight),
        .i_random_fraction (random_fraction),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_picked_index    (picked_index),
        .i_status          (status),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    // Result side: random stall bursts, calm windows, and one long hold-off that backs the
    // block up while items keep being offered.
    always @(posedge clk) begin
        rx_cycles <= rx_cycles + 1;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else if (!long_hold_done && rx_cycles >= HOLD_START) begin
            long_hold_done <= 1'b1;
            stall_left     <= HOLD_CYCLES - 1;
            out_ready      <= 1'b0;
        end else if (!quiet && !rx_cycles[9] && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 10);
            out_ready  <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL area_weighted_entry_picker");
        $finish;
    end

    task automatic send_item(input logic op, input logic [WEIGHT_IN_BITS-1:0] weight,
                             input logic [FRAC_IN_BITS-1:0] fraction, input logic allow_gap);
        int unsigned gap;
        if (allow_gap && !quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 11);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        opcode          <= op;
        entry_weight    <= weight;
        random_fraction <= fraction;
        do @(posedge clk); while (!in_ready);
    endtask

    function automatic logic [WEIGHT_IN_BITS-1:0] random_weight();
        int unsigned kind;
        kind = $urandom_range(0, 7);
        case (kind)
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            2, 3: begin
                return WEIGHT_IN_BITS'($urandom_range(0, 255));
            end
            default: begin
                return WEIGHT_IN_BITS'($urandom);
            end
        endcase
    endfunction

    function automatic logic [FRAC_IN_BITS-1:0] random_draw();
        int unsigned kind;
        kind = $urandom_range(0, 7);
        case (kind)
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            default: begin
                return FRAC_IN_BITS'($urandom);
            end
        endcase
    endfunction

    initial begin
        logic calm;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Picks on an empty table, then a lone zero-weight entry, then a zero total.
        send_item(OP_PICK, 32'h0000_0000, 16'h0000, 1'b1);
        send_item(OP_PICK, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        send_item(OP_ADD, 32'h0000_0000, 16'hFFFF, 1'b1);
        send_item(OP_PICK, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        send_item(OP_ADD, 32'h0000_0000, 16'h0000, 1'b1);
        send_item(OP_PICK, 32'h0000_0000, 16'hFFFF, 1'b1);
        send_item(OP_ADD, 32'hFFFF_FFFF, 16'h0000, 1'b1);
        send_item(OP_PICK, 32'h0000_0000, 16'h0000, 1'b1);
        send_item(OP_PICK, 32'h0000_0000, 16'hFFFF, 1'b1);
        send_item(OP_PICK, 32'h0000_0000, 16'h8000, 1'b1);
        send_item(OP_ADD, 32'h0000_0001, 16'h0000, 1'b1);
        send_item(OP_ADD, 32'h8000_0000, 16'h0000, 1'b1);
        send_item(OP_ADD, 32'h7FFF_FFFF, 16'h0000, 1'b1);
        send_item(OP_ADD, 32'h5555_5555, 16'h0000, 1'b1);
        send_item(OP_ADD, 32'hAAAA_AAAA, 16'h0000, 1'b1);
        send_item(OP_PICK, 32'h0000_0000, 16'h0001, 1'b1);
        send_item(OP_PICK, 32'h0000_0000, 16'h4000, 1'b1);
        send_item(OP_PICK, 32'h0000_0000, 16'hC000, 1'b1);
        send_item(OP_PICK, 32'h0000_0000, 16'hFFFE, 1'b1);

        // Adds come often enough that the table fills well before the end, so later adds
        // are dropped while picks run on a full table.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - QUIET_ITEMS) begin
                quiet <= 1'b1;
            end
            calm = (n % 100) >= 70;
            if ($urandom_range(0, 9) < 4) begin
                send_item(OP_ADD, random_weight(), FRAC_IN_BITS'($urandom), !calm);
            end else begin
                send_item(OP_PICK, WEIGHT_IN_BITS'($urandom), random_draw(), !calm);
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);

        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS area_weighted_entry_picker");
        end else begin
            $display("FAIL area_weighted_entry_picker");
        end
        $finish;
    end

endmodule
